// ===== rtl/ilir_pkg.sv =====
// Shared request, status and cell operation codes for the indexed list.
`default_nettype none

package ilir_pkg;

	// Request codes on req_type
	typedef enum logic [2:0] {
		REQ_APPEND = 3'd0,
		REQ_INSERT = 3'd1,
		REQ_REMOVE = 3'd2,
		REQ_WRITE  = 3'd3,
		REQ_READ   = 3'd4
	} req_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_FULL  = 2'd3
	} stat_t;

	// Operation broadcast to every cell of the chain
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_APPEND,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_WRITE
	} cell_op_t;

	localparam int POS_BITS   = 6;
	localparam int COUNT_BITS = 7;
	localparam int WIN_BITS   = 32;

endpackage

`default_nettype wire

// ===== rtl/ilir_cell.sv =====
// One list entry: holds a word and loads, keeps or takes a neighbor's word.
`default_nettype none

module ilir_cell
	import ilir_pkg::*;
#(
	parameter int WORD_BITS = 32,
	parameter int CMP_W     = 7,
	parameter int IDX       = 0
) (
	input  wire logic                 clk,
	input  wire cell_op_t             op,
	input  wire logic [CMP_W-1:0]     pos_ext,
	input  wire logic [CMP_W-1:0]     count_ext,
	input  wire logic [WORD_BITS-1:0] word_new,
	input  wire logic [WORD_BITS-1:0] lower_word,
	input  wire logic [WORD_BITS-1:0] upper_word,
	output logic      [WORD_BITS-1:0] word,
	output logic                      hit
);

	localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

	logic [WORD_BITS-1:0] word_q;
	logic [WORD_BITS-1:0] word_d;
	logic                 at_pos;
	logic                 above_pos;
	logic                 at_end;

	assign at_pos    = (pos_ext == MY_IDX);
	assign above_pos = (MY_IDX > pos_ext);
	assign at_end    = (count_ext == MY_IDX);

	// next word: insert shifts up from below, remove shifts down from above
	always_comb begin
		word_d = word_q;
		case (op)
			CELL_APPEND: begin
				if (at_end) word_d = word_new;
			end
			CELL_INSERT: begin
				if (at_pos) word_d = word_new;
				else if (above_pos) word_d = lower_word;
			end
			CELL_REMOVE: begin
				if (at_pos || above_pos) word_d = upper_word;
			end
			CELL_WRITE: begin
				if (at_pos) word_d = word_new;
			end
			default: word_d = word_q;
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word = word_q;
	assign hit  = at_pos;

endmodule

`default_nettype wire

// ===== rtl/indexed_list_insert_remove_core.sv =====
// Top level of the indexed list: request decode, count, cell chain and result register.
`default_nettype none

// An ordered list of up to CAPACITY words kept in a chain of cells, one word per
// cell. Append, insert, remove, overwrite and read each act in the accepting clock:
// an insert or remove moves every higher entry one cell along the chain in that
// same cycle. A request beat is accepted whenever the result register is empty
// or its beat leaves in the same cycle, so one request per clock is sustained while
// the receiver does not stall; the result beat appears in the cycle after acceptance.
// The chain's shift in the accepting cycle sets this rate. No clearing pass follows
// reset: only the count is cleared, and entries at or above the count are never read.

module indexed_list_insert_remove_core
	import ilir_pkg::*;
#(
	parameter int CAPACITY  = 64,
	parameter int WORD_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [2:0]            req_type,
	input  wire logic [POS_BITS-1:0]   position,
	input  wire logic [WIN_BITS-1:0]   word_in,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [1:0]                 status,
	output logic [WIN_BITS-1:0]        word_out,
	output logic [COUNT_BITS-1:0]      entry_count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic                 in_fire;
	logic                 out_valid_q;
	stat_t                status_q;
	logic [WIN_BITS-1:0]  word_out_q;
	logic [CNT_W-1:0]     count_q;

	logic [CNT_W-1:0]     count_d;
	stat_t                stat_d;
	cell_op_t             op_d;
	cell_op_t             op_cells;
	logic                 rd_ok;
	logic [CMP_W-1:0]     pos_ext;
	logic [CMP_W-1:0]     count_ext;
	logic                 list_empty;
	logic                 list_full;
	logic                 in_range;
	logic [63:0]          win_wide;
	logic [WORD_BITS-1:0] word_st;
	logic [WORD_BITS-1:0] cell_word [CAPACITY];
	logic                 cell_hit  [CAPACITY];
	logic [WORD_BITS-1:0] rd_sel;
	logic [63:0]          rd_wide;

	// handshake
	assign in_stall = out_valid_q && out_stall;
	assign in_fire  = in_valid && !in_stall;

	assign pos_ext    = CMP_W'(position);
	assign count_ext  = CMP_W'(count_q);
	assign list_empty = (count_q == '0);
	assign list_full  = (count_q == CAP_CNT);
	assign in_range   = (pos_ext < count_ext);

	assign win_wide = {32'b0, word_in};
	assign word_st  = win_wide[WORD_BITS-1:0];

	// request decode: status, next count and chain operation
	always_comb begin
		stat_d  = STAT_OK;
		count_d = count_q;
		op_d    = CELL_HOLD;
		rd_ok   = 1'b0;
		unique case (req_type) inside
			REQ_APPEND: begin
				if (list_full) stat_d = STAT_FULL;
				else begin
					op_d    = CELL_APPEND;
					count_d = CNT_W'(count_q + 1'b1);
				end
			end
			REQ_INSERT: begin
				if (list_empty) stat_d = STAT_EMPTY;
				else if (!in_range) stat_d = STAT_RANGE;
				else if (list_full) stat_d = STAT_FULL;
				else begin
					op_d    = CELL_INSERT;
					count_d = CNT_W'(count_q + 1'b1);
				end
			end
			REQ_REMOVE, REQ_WRITE, REQ_READ: begin
				if (list_empty) stat_d = STAT_EMPTY;
				else if (!in_range) stat_d = STAT_RANGE;
				else if (req_type == REQ_REMOVE) begin
					op_d    = CELL_REMOVE;
					count_d = CNT_W'(count_q - 1'b1);
				end else if (req_type == REQ_WRITE) begin
					op_d = CELL_WRITE;
				end else begin
					rd_ok = 1'b1;
				end
			end
			default: stat_d = STAT_OK;
		endcase
	end

	assign op_cells = in_fire ? op_d : CELL_HOLD;

	// cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_BITS-1:0] lower_w;
		logic [WORD_BITS-1:0] upper_w;
		if (i == 0) begin : g_first
			assign lower_w = '0;
		end else begin : g_mid_lo
			assign lower_w = cell_word[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper_w = '0;
		end else begin : g_mid_hi
			assign upper_w = cell_word[i+1];
		end
		ilir_cell #(
			.WORD_BITS (WORD_BITS),
			.CMP_W     (CMP_W),
			.IDX       (i)
		) u_cell (
			.clk        (clk),
			.op         (op_cells),
			.pos_ext    (pos_ext),
			.count_ext  (count_ext),
			.word_new   (word_st),
			.lower_word (lower_w),
			.upper_word (upper_w),
			.word       (cell_word[i]),
			.hit        (cell_hit[i])
		);
	end

	// read select: the one cell at the index drives the read word
	always_comb begin
		rd_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cell_hit[i]) rd_sel = rd_sel | cell_word[i];
		end
	end

	assign rd_wide = 64'(rd_sel);

	// count and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			status_q   <= stat_d;
			word_out_q <= rd_ok ? rd_wide[WIN_BITS-1:0] : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign word_out    = word_out_q;
	assign entry_count = COUNT_BITS'(count_q);

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("entry count beyond capacity");

	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid_q)
		else $error("accepted beat produced no result");

	a_count_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (entry_count == COUNT_BITS'(count_q)))
		else $error("result count differs from list count");

	a_word_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (word_out_q != '0)) |-> (status_q == STAT_OK))
		else $error("read word present on a failed request");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the indexed list core: queued requests, predicted results.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ilir_pkg::*;

	localparam int LIST_DEPTH       = 64;
	localparam int ITEM_TARGET      = 1150;
	localparam int LONG_HOLD_AT     = 300;
	localparam int LONG_HOLD_CYCLES = 120;
	localparam int SETTLE_CYCLES    = 10;
	localparam logic [2:0] REQ_SPARE_LO = 3'd5;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;

	// Random phase kinds
	localparam int PH_GROW   = 0;
	localparam int PH_SHRINK = 1;
	localparam int PH_CHURN  = 2;
	localparam int PH_NOISE  = 3;

	typedef struct {
		logic [2:0]  req;
		logic [5:0]  pos;
		logic [31:0] word;
		bit          drain;
	} list_req_t;

	typedef struct {
		stat_t       status;
		logic [31:0] word;
		logic [6:0]  count;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] req_type = '0;
	logic [POS_BITS-1:0] position = '0;
	logic [WIN_BITS-1:0] word_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [WIN_BITS-1:0] word_out;
	logic [COUNT_BITS-1:0] entry_count;

	list_req_t    pending[$];
	list_result_t results_due[$];

	// Predicted list contents and length
	logic [31:0] list_words [LIST_DEPTH];
	int list_len = 0;

	int plan_count = 0;
	int planned_real = 0;
	int sent_total = 0;
	int results_checked = 0;
	int errors = 0;
	int idle_left = 0;
	int stall_left = 0;
	int stall_roll;
	int full_hits = 0;
	int req_seen [8];
	int status_seen [4];
	bit long_hold_done = 1'b0;
	bit take;
	list_req_t    head;
	list_result_t due;

	indexed_list_insert_remove_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.position    (position),
		.word_in     (word_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.word_out    (word_out),
		.entry_count (entry_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one request to the predicted list and return its result
	function automatic list_result_t apply_list_request(logic [2:0] req, logic [5:0] pos,
			logic [31:0] word);
		list_result_t res;
		int i;
		res.status = STAT_OK;
		res.word = '0;
		case (req)
			REQ_APPEND: begin
				if (list_len >= LIST_DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					list_words[list_len] = word;
					list_len++;
				end
			end
			REQ_INSERT: begin
				// index checks take priority over the full check
				if (list_len == 0) begin
					res.status = STAT_EMPTY;
				end else if (pos >= list_len) begin
					res.status = STAT_RANGE;
				end else if (list_len >= LIST_DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					for (i = list_len; i > pos; i--)
						list_words[i] = list_words[i-1];
					list_words[pos] = word;
					list_len++;
				end
			end
			REQ_REMOVE, REQ_WRITE, REQ_READ: begin
				if (list_len == 0) begin
					res.status = STAT_EMPTY;
				end else if (pos >= list_len) begin
					res.status = STAT_RANGE;
				end else if (req == REQ_REMOVE) begin
					list_len--;
					for (i = pos; i < list_len; i++)
						list_words[i] = list_words[i+1];
				end else if (req == REQ_WRITE) begin
					list_words[pos] = word;
				end else begin
					res.word = list_words[pos];
				end
			end
			default: ;
		endcase
		if (list_len == LIST_DEPTH && res.status == STAT_OK &&
				(req == REQ_APPEND || req == REQ_INSERT))
			full_hits++;
		res.count = list_len[6:0];
		return res;
	endfunction

	// Queue one request and track the length it leaves behind
	task automatic queue_item(logic [2:0] req, logic [5:0] pos, logic [31:0] word,
			bit drain = 1'b0);
		list_req_t it;
		it.req = req;
		it.pos = pos;
		it.word = word;
		it.drain = drain;
		pending.push_back(it);
		case (req)
			REQ_APPEND: if (plan_count < LIST_DEPTH) plan_count++;
			REQ_INSERT: if (plan_count != 0 && pos < plan_count && plan_count < LIST_DEPTH)
				plan_count++;
			REQ_REMOVE: if (plan_count != 0 && pos < plan_count) plan_count--;
			default: ;
		endcase
		if (req <= REQ_READ)
			planned_real++;
	endtask

	// Mostly in-range indexes, sometimes anywhere in the field
	function automatic logic [5:0] pick_pos(bit wild);
		if (wild || plan_count == 0 || $urandom_range(0, 7) == 0)
			return 6'($urandom_range(0, 63));
		if ($urandom_range(0, 9) == 0)
			return 6'(plan_count - 1);
		return 6'($urandom_range(0, plan_count - 1));
	endfunction

	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if ((sent_total / 100) % 4 == 1)
			return 0;
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Driver: predicts on each accepted beat, then offers the next queued request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= '0;
			position <= '0;
			word_in <= '0;
			idle_left <= 0;
		end else begin
			take = in_valid && !in_stall;
			if (take) begin
				results_due.push_back(apply_list_request(req_type, position, word_in));
				req_seen[req_type]++;
				sent_total++;
			end
			if (!in_valid || take) begin
				if (idle_left > 0) begin
					idle_left <= idle_left - 1;
					in_valid <= 1'b0;
				end else if (pending.size() != 0 &&
						!(pending[0].drain && results_due.size() != 0)) begin
					head = pending.pop_front();
					in_valid <= 1'b1;
					req_type <= head.req;
					position <= head.pos;
					word_in <= head.word;
					idle_left <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result beat: status %0d word %h count %0d",
					$time, status, word_out, entry_count);
				errors++;
			end else begin
				due = results_due.pop_front();
				status_seen[due.status]++;
				if (status !== due.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, due.status, status);
					errors++;
				end
				if (word_out !== due.word) begin
					$display("%0t: word_out mismatch: expected %h, actual %h",
						$time, due.word, word_out);
					errors++;
				end
				if (entry_count !== due.count) begin
					$display("%0t: entry_count mismatch: expected %0d, actual %0d",
						$time, due.count, entry_count);
					errors++;
				end
			end
		end
	end

	// Receiver stalls: random runs, quiet stretches, and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			long_hold_done <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!long_hold_done && results_checked >= LONG_HOLD_AT) begin
			long_hold_done <= 1'b1;
			stall_left <= LONG_HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if ((results_checked / 150) % 3 == 2) begin
			out_stall <= 1'b0;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 65) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				if (stall_roll < 90)
					stall_left <= $urandom_range(0, 2);
				else if (stall_roll < 98)
					stall_left <= $urandom_range(3, 11);
				else
					stall_left <= $urandom_range(19, 39);
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int phase;
		int kind;
		int steps;
		int extra;
		int r;
		logic [2:0] req;
		bit wild;

		// empty list: insert, remove, overwrite, read, unused codes, top bits of every field
		queue_item(REQ_READ, 6'd0, 32'h0);
		queue_item(REQ_INSERT, 6'd0, 32'h1234_5678);
		queue_item(REQ_REMOVE, 6'd0, 32'h0);
		queue_item(REQ_WRITE, 6'd0, 32'hffff_ffff);
		queue_item(REQ_SPARE_LO, 6'd63, 32'hffff_ffff);
		queue_item(3'd6, 6'd63, 32'hffff_ffff);
		queue_item(REQ_SPARE_HI, 6'd63, 32'hffff_ffff);
		// small list: in-range and out-of-range indexes at both ends
		queue_item(REQ_APPEND, 6'd0, 32'h0);
		queue_item(REQ_APPEND, 6'd63, 32'hffff_ffff);
		queue_item(REQ_APPEND, 6'd0, 32'ha5a5_a5a5);
		queue_item(REQ_INSERT, 6'd0, 32'h0000_0001);
		queue_item(REQ_INSERT, 6'd4, 32'h5a5a_5a5a);
		queue_item(REQ_INSERT, 6'd63, 32'h5a5a_5a5a);
		queue_item(REQ_READ, 6'd0, 32'h0);
		queue_item(REQ_READ, 6'd3, 32'h0);
		queue_item(REQ_READ, 6'd4, 32'h0);
		queue_item(REQ_WRITE, 6'd3, 32'hdead_beef);
		queue_item(REQ_WRITE, 6'd63, 32'h0);
		queue_item(REQ_REMOVE, 6'd4, 32'h0);
		queue_item(REQ_REMOVE, 6'd0, 32'h0);
		queue_item(REQ_REMOVE, 6'd2, 32'h0);
		queue_item(REQ_READ, 6'd1, 32'h0);
		queue_item(REQ_READ, 6'd63, 32'h0);

		// random phases: fill to full, drain to empty, mixed traffic, noise
		phase = 0;
		while (planned_real < ITEM_TARGET) begin
			kind = phase % 4;
			steps = 0;
			extra = $urandom_range(5, 15);
			while (extra > 0 && steps < 250) begin
				r = $urandom_range(0, 99);
				wild = 1'b0;
				case (kind)
					PH_GROW: begin
						req = r < 45 ? REQ_APPEND : r < 75 ? REQ_INSERT :
							r < 85 ? REQ_WRITE : r < 95 ? REQ_READ : REQ_REMOVE;
						if (plan_count == LIST_DEPTH)
							extra--;
					end
					PH_SHRINK: begin
						req = r < 55 ? REQ_REMOVE : r < 62 ? REQ_APPEND :
							r < 70 ? REQ_INSERT : r < 85 ? REQ_READ : REQ_WRITE;
						if (plan_count == 0)
							extra--;
					end
					PH_CHURN: begin
						req = 3'($urandom_range(REQ_APPEND, REQ_READ));
						if (steps >= 60)
							extra--;
					end
					default: begin
						req = r < 15 ? 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)) :
							3'($urandom_range(REQ_APPEND, REQ_READ));
						wild = 1'b1;
						if (steps >= 40)
							extra--;
					end
				endcase
				// every fourth phase starts only after all results are back
				queue_item(req, pick_pos(wild), pick_word(),
					steps == 0 && kind == PH_GROW && phase > 0);
				steps++;
			end
			phase++;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || in_valid || results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Checked %0d results: %0d ok, %0d empty, %0d out of range, %0d full.",
			results_checked, status_seen[STAT_OK], status_seen[STAT_EMPTY],
			status_seen[STAT_RANGE], status_seen[STAT_FULL]);
		$display("Requests: %0d append, %0d insert, %0d remove, %0d overwrite, %0d read, "
			, req_seen[REQ_APPEND], req_seen[REQ_INSERT], req_seen[REQ_REMOVE],
			req_seen[REQ_WRITE], req_seen[REQ_READ],
			"%0d unused codes; list filled %0d times.",
			req_seen[5] + req_seen[6] + req_seen[7], full_hits);
		if (errors == 0) begin
			$display("indexed_list_insert_remove_core test passed");
		end else begin
			$display("indexed_list_insert_remove_core test failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("indexed_list_insert_remove_core test failed");
		$finish;
	end

endmodule
